// ===== rtl/q248_pkg.sv =====
// Package for the Q24.8 fixed-point ALU: opcodes, operation classes, defaults.
// No dependencies; every rtl file refers to it by scoped names.
package q248_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 8;

  // Queue of decoded entries between the front and back parts
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  typedef enum logic [3:0] {
    FN_ADD     = 4'd0,
    FN_SUB     = 4'd1,
    FN_MUL     = 4'd2,
    FN_DIV     = 4'd3,
    FN_LT      = 4'd4,
    FN_GT      = 4'd5,
    FN_LE      = 4'd6,
    FN_GE      = 4'd7,
    FN_EQ      = 4'd8,
    FN_NE      = 4'd9,
    FN_MIN     = 4'd10,
    FN_MAX     = 4'd11,
    FN_INC     = 4'd12,
    FN_DEC     = 4'd13,
    FN_TOINT   = 4'd14,
    FN_FROMINT = 4'd15
  } func_e;

  // Which back-end unit finishes the transaction
  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_MUL    = 2'd1,
    KIND_DIV    = 2'd2
  } kind_e;

endpackage

// ===== rtl/q248_front.sv =====
// Front part: decodes the opcode, finishes single-step operations and
// prepares operand magnitudes for the divider. Uses q248_pkg.
module q248_front #(
  parameter int unsigned DATA_WIDTH = q248_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = q248_pkg::FRAC_BITS_DEF
) (
  input  logic [3:0]                                  func_i,
  input  logic signed [DATA_WIDTH-1:0]                operand_a_i,
  input  logic signed [DATA_WIDTH-1:0]                operand_b_i,
  output logic [5*DATA_WIDTH+FRAC_BITS+3:0]           entry_o
);

  localparam int unsigned QW = DATA_WIDTH + FRAC_BITS;

  typedef struct packed {
    q248_pkg::kind_e              kind;
    logic [DATA_WIDTH-1:0]        res;
    logic                         flag;
    logic signed [DATA_WIDTH-1:0] a;
    logic signed [DATA_WIDTH-1:0] b;
    logic [QW-1:0]                nmag;
    logic [DATA_WIDTH-1:0]        dmag;
    logic                         neg;
  } entry_t;

  entry_t              e;
  logic signed [QW-1:0] num;
  logic                 a_lt_b;
  logic                 a_eq_b;

  assign num    = {operand_a_i, {FRAC_BITS{1'b0}}};
  assign a_lt_b = operand_a_i < operand_b_i;
  assign a_eq_b = operand_a_i == operand_b_i;

  always_comb begin
    e      = '0;
    e.kind = q248_pkg::KIND_SIMPLE;
    e.a    = operand_a_i;
    e.b    = operand_b_i;
    e.nmag = operand_a_i[DATA_WIDTH-1] ? QW'(-num) : QW'(num);
    e.dmag = operand_b_i[DATA_WIDTH-1] ? DATA_WIDTH'(-operand_b_i)
                                       : DATA_WIDTH'(operand_b_i);
    e.neg  = operand_a_i[DATA_WIDTH-1] ^ operand_b_i[DATA_WIDTH-1];
    case (q248_pkg::func_e'(func_i))
      q248_pkg::FN_ADD:     e.res = DATA_WIDTH'(operand_a_i + operand_b_i);
      q248_pkg::FN_SUB:     e.res = DATA_WIDTH'(operand_a_i - operand_b_i);
      q248_pkg::FN_MUL:     e.kind = q248_pkg::KIND_MUL;
      q248_pkg::FN_DIV:     e.kind = q248_pkg::KIND_DIV;
      q248_pkg::FN_LT:      e.flag = a_lt_b;
      q248_pkg::FN_GT:      e.flag = !a_lt_b && !a_eq_b;
      q248_pkg::FN_LE:      e.flag = a_lt_b || a_eq_b;
      q248_pkg::FN_GE:      e.flag = !a_lt_b;
      q248_pkg::FN_EQ:      e.flag = a_eq_b;
      q248_pkg::FN_NE:      e.flag = !a_eq_b;
      q248_pkg::FN_MIN:     e.res = a_lt_b ? operand_a_i : operand_b_i;
      q248_pkg::FN_MAX:     e.res = a_lt_b ? operand_b_i : operand_a_i;
      q248_pkg::FN_INC:     e.res = DATA_WIDTH'(operand_a_i + 1'b1);
      q248_pkg::FN_DEC:     e.res = DATA_WIDTH'(operand_a_i - 1'b1);
      q248_pkg::FN_TOINT:   e.res = DATA_WIDTH'(operand_a_i >>> FRAC_BITS);
      q248_pkg::FN_FROMINT: e.res = DATA_WIDTH'(operand_a_i << FRAC_BITS);
      default:              e.res = '0;
    endcase
  end

  assign entry_o = e;

endmodule

// ===== rtl/q248_fifo.sv =====
// Short queue decoupling the front part from the execution pipeline.
// Uses q248_pkg for depth and pointer widths.
module q248_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             valid_o
);

  logic [WIDTH-1:0]                    mem_q [q248_pkg::FIFO_DEPTH];
  logic [q248_pkg::FIFO_PTR_W-1:0]     wr_q, rd_q;
  logic [q248_pkg::FIFO_CNT_W-1:0]     cnt_q, cnt_d;

  assign ready_o = cnt_q != q248_pkg::FIFO_CNT_W'(q248_pkg::FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != q248_pkg::FIFO_CNT_W'(q248_pkg::FIFO_DEPTH))
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue popped while empty");

endmodule

// ===== rtl/q248_back.sv =====
// Back part: in-order execution pipeline with a registered multiplier, a
// one-bit-per-stage restoring divider and the output register. Uses q248_pkg.
module q248_back #(
  parameter int unsigned DATA_WIDTH = q248_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = q248_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [5*DATA_WIDTH+FRAC_BITS+3:0] entry_i,
  input  logic                              entry_valid_i,
  output logic                              pop_o,
  output logic [DATA_WIDTH-1:0]             result_o,
  output logic                              flag_o,
  output logic                              valid_o,
  input  logic                              ready_i
);

  localparam int unsigned QW = DATA_WIDTH + FRAC_BITS;
  localparam int unsigned PW = 2 * DATA_WIDTH;

  typedef struct packed {
    q248_pkg::kind_e              kind;
    logic [DATA_WIDTH-1:0]        res;
    logic                         flag;
    logic signed [DATA_WIDTH-1:0] a;
    logic signed [DATA_WIDTH-1:0] b;
    logic [QW-1:0]                nmag;
    logic [DATA_WIDTH-1:0]        dmag;
    logic                         neg;
  } entry_t;

  entry_t                ein;
  logic                  advance;
  logic [QW-1:0]         vld_q;
  logic [DATA_WIDTH-1:0] rem_q  [QW];
  logic [QW-1:0]         nq_q   [QW];
  logic [DATA_WIDTH-1:0] den_q  [QW];
  logic                  neg_q  [QW];
  q248_pkg::kind_e       kind_q [QW];
  logic [DATA_WIDTH-1:0] res_q  [QW];
  logic                  flag_q [QW];
  logic signed [PW-1:0]  prod_q;
  logic signed [PW-1:0]  prod_rnd;
  logic [DATA_WIDTH-1:0] mul_res;
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] out_res_q, out_res_d;
  logic                  out_flag_q, out_flag_d;
  logic [DATA_WIDTH-1:0] quo;

  assign ein     = entry_i;
  // whole pipeline moves when the output register is free or being taken
  assign advance = !out_valid_q || ready_i;
  assign pop_o   = advance && entry_valid_i;

  // ceiling by FRAC_BITS: add all-ones fraction then floor
  assign prod_rnd = prod_q + PW'({FRAC_BITS{1'b1}});
  assign mul_res  = DATA_WIDTH'(prod_rnd >>> FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (advance) prod_q <= PW'(ein.a) * PW'(ein.b);
  end

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DATA_WIDTH-1:0] rem_in, den_in, res_in, res_nx;
    logic [QW-1:0]         nq_in;
    logic                  neg_in, flag_in;
    q248_pkg::kind_e       kind_in;
    logic [DATA_WIDTH:0]   trial;
    logic                  ge;

    if (i == 0) begin : g_head
      assign rem_in  = '0;
      assign nq_in   = ein.nmag;
      assign den_in  = ein.dmag;
      assign neg_in  = ein.neg;
      assign kind_in = ein.kind;
      assign res_in  = ein.res;
      assign flag_in = ein.flag;
    end else begin : g_body
      assign rem_in  = rem_q[i-1];
      assign nq_in   = nq_q[i-1];
      assign den_in  = den_q[i-1];
      assign neg_in  = neg_q[i-1];
      assign kind_in = kind_q[i-1];
      assign res_in  = res_q[i-1];
      assign flag_in = flag_q[i-1];
    end

    if (i == 1) begin : g_mul
      assign res_nx = (kind_in == q248_pkg::KIND_MUL) ? mul_res : res_in;
    end else begin : g_pass
      assign res_nx = res_in;
    end

    assign trial = {rem_in, nq_in[QW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (advance) begin
        rem_q[i]  <= ge ? DATA_WIDTH'(trial - {1'b0, den_in}) : trial[DATA_WIDTH-1:0];
        nq_q[i]   <= {nq_in[QW-2:0], ge};
        den_q[i]  <= den_in;
        neg_q[i]  <= neg_in;
        kind_q[i] <= kind_in;
        res_q[i]  <= res_nx;
        flag_q[i] <= flag_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[QW-2:0], entry_valid_i};
    end
  end

  assign quo = nq_q[QW-1][DATA_WIDTH-1:0];

  always_comb begin
    out_res_d  = res_q[QW-1];
    out_flag_d = flag_q[QW-1];
    if (kind_q[QW-1] == q248_pkg::KIND_DIV) begin
      if (den_q[QW-1] == '0) begin
        out_res_d  = '0;
        out_flag_d = 1'b1;
      end else begin
        out_res_d  = neg_q[QW-1] ? DATA_WIDTH'(-quo) : quo;
        out_flag_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= vld_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q  <= out_res_d;
      out_flag_q <= out_flag_d;
    end
  end

  assign result_o = out_res_q;
  assign flag_o   = out_flag_q;
  assign valid_o  = out_valid_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(vld_q))
    else $error("pipeline moved while output stalled");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !vld_q[QW-1]) |=> !out_valid_q)
    else $error("result appeared without a transaction behind it");

endmodule

// ===== rtl/fixed_point_q24_8_alu_top.sv =====
// Q24.8 fixed-point ALU, top level: front decode, queue, execution pipeline.
// Every opcode takes the same path: queue, divider stages, output register.
// Throughput: one transaction per cycle while the output is taken; the divider has one stage per
// quotient bit, and all operations travel the same depth to keep order.
// Reset (rst_ni, asynchronous, active low) empties the queue and pipeline.
// Depends on q248_pkg, q248_front, q248_fifo, q248_back.
module fixed_point_q24_8_alu_top #(
  parameter int unsigned DATA_WIDTH = q248_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = q248_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // slave side
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: operand_a, operand_b, zero fill to bytes
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  // tuser: func
  input  logic [3:0]                               s_axis_tuser,
  // master side
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // tdata: result_raw, zero fill to bytes
  output logic [((DATA_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
  // tuser: flag
  output logic [0:0]                               m_axis_tuser
);

  localparam int unsigned ENTRY_W = 5 * DATA_WIDTH + FRAC_BITS + 4;
  localparam int unsigned OUT_W   = ((DATA_WIDTH + 7) / 8) * 8;

  logic [ENTRY_W-1:0]    front_entry;
  logic [ENTRY_W-1:0]    head_entry;
  logic                  head_valid;
  logic                  head_pop;
  logic                  push;
  logic [DATA_WIDTH-1:0] result;
  logic                  flag;

  // a transaction is taken whenever it is valid and the queue has room
  assign push = s_axis_tvalid && s_axis_tready;

  q248_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .func_i      (s_axis_tuser),
    .operand_a_i (s_axis_tdata[DATA_WIDTH-1:0]),
    .operand_b_i (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .entry_o     (front_entry)
  );

  q248_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_entry),
    .ready_o (s_axis_tready),
    .pop_i   (head_pop),
    .data_o  (head_entry),
    .valid_o (head_valid)
  );

  // back end stalls as a whole only when its output register is held
  q248_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (head_entry),
    .entry_valid_i (head_valid),
    .pop_o         (head_pop),
    .result_o      (result),
    .flag_o        (flag),
    .valid_o       (m_axis_tvalid),
    .ready_i       (m_axis_tready)
  );

  assign m_axis_tdata = OUT_W'(result);
  assign m_axis_tuser = flag;

endmodule
